>>> rtl/gmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_pkg
// shared types and constants of the grid max path sum block
// ----------------------------------------------------------------------------
package gmps_pkg;

    localparam int VAL_W  = 16;   // cell value width
    localparam int SUM_W  = 23;   // best sum width
    localparam int CFG_W  = 7;    // configuration register width
    localparam int ADDR_W = 1;    // configuration register index width
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic [CFG_W-1:0] GRID_ROWS_RESET = 7'd5;
    localparam logic [CFG_W-1:0] GRID_COLS_RESET = 7'd6;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [ADDR_W-1:0] REG_GRID_COLS = 1'd1;

    // one best-sum entry with its reachable bit
    typedef struct packed {
        logic             ok;
        logic [SUM_W-1:0] sum;
    } entry_t;

    // position of the current cell inside the grid
    typedef struct packed {
        logic first_row;
        logic first_col;
    } pos_flags_t;

endpackage

>>> rtl/gmps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_cell
// one stage of the row buffer chain
// ----------------------------------------------------------------------------
module gmps_cell
(
    input  logic              clk,
    input  logic              shift_en,
    input  logic              is_tail,
    input  gmps_pkg::entry_t  new_entry,
    input  gmps_pkg::entry_t  next_entry,
    output gmps_pkg::entry_t  entry
);

    gmps_pkg::entry_t data_reg;
    gmps_pkg::entry_t data_next;

    // the tail cell takes the fresh entry, the others take their neighbor's
    always_comb
    begin
        data_next = is_tail ? new_entry : next_entry;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= data_next;
        end
    end

    assign entry = data_reg;

endmodule

>>> rtl/gmps_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_chain
// row of cells holding the best sums of the last grid-width cells
// ----------------------------------------------------------------------------
module gmps_chain
#(
    parameter int NUM_CELLS = 64,
    parameter int COL_W     = 6
)
(
    input  logic              clk,
    input  logic              shift_en,
    input  logic [COL_W-1:0]  tail_idx,
    input  gmps_pkg::entry_t  new_entry,
    output gmps_pkg::entry_t  head_entry
);

    gmps_pkg::entry_t cell_q [NUM_CELLS];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        gmps_pkg::entry_t nbr;

        if (i == NUM_CELLS - 1)
        begin : g_end
            assign nbr = new_entry;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i+1];
        end

        gmps_cell u_cell
        (
            .clk        (clk),
            .shift_en   (shift_en),
            .is_tail    (tail_idx == COL_W'(i)),
            .new_entry  (new_entry),
            .next_entry (nbr),
            .entry      (cell_q[i])
        );
    end

    // entry written one grid width ago: the cell above
    assign head_entry = cell_q[0];

endmodule

>>> rtl/gmps_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_update
// best sum of one cell from its upper and left neighbors
// ----------------------------------------------------------------------------
module gmps_update
(
    input  logic                        is_rock,
    input  logic [gmps_pkg::VAL_W-1:0]  cell_value,
    input  gmps_pkg::pos_flags_t        pos,
    input  gmps_pkg::entry_t            above,
    input  gmps_pkg::entry_t            left,
    output gmps_pkg::entry_t            result
);

    logic                        above_ok;
    logic                        left_ok;
    logic [gmps_pkg::SUM_W-1:0]  pick;
    logic [gmps_pkg::SUM_W:0]    total;

    always_comb
    begin
        above_ok = !pos.first_row && above.ok;
        left_ok  = !pos.first_col && left.ok;

        if (above_ok && (!left_ok || above.sum >= left.sum))
        begin
            pick = above.sum;
        end
        else
        begin
            pick = left.sum;
        end

        total = {1'b0, pick} + (gmps_pkg::SUM_W + 1)'(cell_value);

        if (pos.first_row && pos.first_col)
        begin
            // start cell is always reachable
            result.ok  = 1'b1;
            result.sum = is_rock ? '0 : gmps_pkg::SUM_W'(cell_value);
        end
        else if (is_rock || !(above_ok || left_ok))
        begin
            result.ok  = 1'b0;
            result.sum = '0;
        end
        else
        begin
            result.ok  = 1'b1;
            result.sum = total[gmps_pkg::SUM_W] ? gmps_pkg::SUM_MAX
                                                : total[gmps_pkg::SUM_W-1:0];
        end
    end

endmodule

>>> rtl/grid_max_path_sum_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_max_path_sum_core
// best right/down path sum through a grid of cells with rocks
// ----------------------------------------------------------------------------
// usage:
//   cells come in on the s_ stream in raster order, one request per cell:
//   s_tdata is the cell value, s_tuser the rock flag. after the last cell
//   of a grid one result request leaves on the m_ stream: m_tdata holds
//   the best path sum (0 when no path), m_tuser says the end is reachable.
//   grid size is set through the cfg_ write port (index 0 rows, index 1
//   columns); any write restarts the scan at the top-left cell.
// throughput: one cell per clock unless the last cell of a grid is held off,
//   set by the combinational max and add of the update unit against the
//   head of the cell chain and the left register.
// latency: the result sits in the output register the cycle after the
//   last cell of the grid is taken.
// reset: scan position at the top-left cell, grid size 5 rows by 6 columns,
//   output empty. the chain of cells is not cleared; row 0 fills it before
//   it is ever read.
// stall: cells keep flowing while a result waits; only the last cell of the
//   next grid is held off until the waiting result has been taken.
// ----------------------------------------------------------------------------
module grid_max_path_sum_core
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [gmps_pkg::ADDR_W-1:0]       cfg_addr,
    input  logic [gmps_pkg::CFG_W-1:0]        cfg_wdata,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gmps_pkg::IN_DATA_W-1:0]    s_tdata,   // [15:0] cell_value
    input  logic                              s_tuser,   // [0] is_rock

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gmps_pkg::OUT_DATA_W-1:0]   m_tdata,   // [22:0] best_amount, [23] zero
    output logic                              m_tuser    // [0] path_found
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // last index in use, with zero read as one and large values clamped
    function automatic logic [COL_W-1:0] last_col(input logic [gmps_pkg::CFG_W-1:0] v);
        if (v == '0)
        begin
            return '0;
        end
        if (32'(v) > 32'(MAX_COLS))
        begin
            return COL_W'(MAX_COLS - 1);
        end
        return COL_W'(32'(v) - 32'd1);
    endfunction

    function automatic logic [ROW_W-1:0] last_row(input logic [gmps_pkg::CFG_W-1:0] v);
        if (v == '0)
        begin
            return '0;
        end
        if (32'(v) > 32'(MAX_ROWS))
        begin
            return ROW_W'(MAX_ROWS - 1);
        end
        return ROW_W'(32'(v) - 32'd1);
    endfunction

    // grid size
    logic [COL_W-1:0] cols_last_reg;
    logic [ROW_W-1:0] rows_last_reg;

    // scan position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // left neighbor
    gmps_pkg::entry_t left_reg;
    gmps_pkg::entry_t left_next;

    // output register
    logic                          out_valid_reg;
    logic [gmps_pkg::SUM_W-1:0]    out_sum_reg;
    logic                          out_found_reg;

    logic                 in_req;
    logic                 at_row_end;
    logic                 at_grid_end;
    gmps_pkg::pos_flags_t pos;
    gmps_pkg::entry_t     above;
    gmps_pkg::entry_t     fresh;

    assign at_row_end  = (col_reg == cols_last_reg);
    assign at_grid_end = at_row_end && (row_reg == rows_last_reg);

    // the last cell of a grid needs a free output register
    assign s_tready = !(at_grid_end && out_valid_reg && !m_tready);
    assign in_req   = s_tvalid && s_tready;

    assign pos.first_row = (row_reg == '0);
    assign pos.first_col = (col_reg == '0);

    gmps_chain
    #(
        .NUM_CELLS (MAX_COLS),
        .COL_W     (COL_W)
    )
    u_chain
    (
        .clk        (clk),
        .shift_en   (in_req),
        .tail_idx   (cols_last_reg),
        .new_entry  (fresh),
        .head_entry (above)
    );

    gmps_update u_update
    (
        .is_rock    (s_tuser),
        .cell_value (s_tdata),
        .pos        (pos),
        .above      (above),
        .left       (left_reg),
        .result     (fresh)
    );

    // next scan position and left neighbor
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (in_req)
        begin
            if (at_row_end)
            begin
                col_next  = '0;
                left_next = '0;
                row_next  = at_grid_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next  = col_reg + COL_W'(1);
                left_next = fresh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_last_reg <= last_col(gmps_pkg::GRID_COLS_RESET);
            rows_last_reg <= last_row(gmps_pkg::GRID_ROWS_RESET);
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
        end
        else if (cfg_we)
        begin
            // any write of a known register starts a new grid
            unique case (cfg_addr)
                gmps_pkg::REG_GRID_ROWS:
                begin
                    rows_last_reg <= last_row(cfg_wdata);
                    col_reg       <= '0;
                    row_reg       <= '0;
                    left_reg      <= '0;
                end
                gmps_pkg::REG_GRID_COLS:
                begin
                    cols_last_reg <= last_col(cfg_wdata);
                    col_reg       <= '0;
                    row_reg       <= '0;
                    left_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_req && at_grid_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req && at_grid_end)
        begin
            out_sum_reg   <= fresh.ok ? fresh.sum : '0;
            out_found_reg <= fresh.ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = gmps_pkg::OUT_DATA_W'(out_sum_reg);
    assign m_tuser  = out_found_reg;

endmodule

>>> rtl/gmps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_checker
// port-level checks of the grid max path sum block
// ----------------------------------------------------------------------------
module gmps_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [gmps_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no path means a zero sum, and a valid result has a clear pad bit
    a_no_path_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser || m_tdata == '0) && !m_tdata[gmps_pkg::OUT_DATA_W-1])
        else $error("bad result encoding");

    // input is held off only behind a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // a result only follows an accepted cell
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an input request");

endmodule

bind grid_max_path_sum_core gmps_checker u_gmps_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb_grid_max_path_sum_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_max_path_sum_core
// self-checking bench for the grid max path sum block
// ----------------------------------------------------------------------------
// cells are streamed in raster order under random pacing on both sides and
// every result request is compared with a cycle-free predictor that keeps its
// own row of best sums. a short directed table covers 1x1 grids, rock starts
// and ends, walled-off ends and a restart in the middle of a grid; random
// phases then sweep grid shapes up to the clamped extremes.
// ----------------------------------------------------------------------------
module tb_grid_max_path_sum_core;

    import gmps_pkg::*;

    localparam int          GRID_MAX      = 64;        // rows and columns of the instance
    localparam int          TOTAL_CELLS   = 1550;      // stop sending after this many cells
    localparam int          SETTLE_CYCLES = 4;         // output register plus margin
    localparam int          HOLD_CYCLES   = 300;       // long receiver hold-off
    localparam int          DRAIN_CYCLES  = 10;
    localparam longint      TIMEOUT_NS    = 64'd5_000_000;

    // ------------------------------------------------------------------------
    // directed stimulus rows
    // ------------------------------------------------------------------------
    typedef enum logic { ROW_CFG, ROW_CELL } row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [ADDR_W-1:0]  addr;      // register index of a config row
        logic [CFG_W-1:0]   wdata;     // register value of a config row
        logic               rock;
        logic [VAL_W-1:0]   value;
        logic               typed;     // result below is known by hand
        logic [SUM_W-1:0]   amount;
        logic               found;
    } stim_row_t;

    typedef struct packed {
        logic [SUM_W-1:0]   amount;
        logic               found;
    } path_result_t;

    localparam int N_DIRECTED = 24;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // 1x1 grid: rows and columns written as 0, both clamp to 1
        '{ROW_CFG,  REG_GRID_ROWS, 7'd0, 1'b0, 16'd0,     1'b0, 23'd0,      1'b0},
        '{ROW_CFG,  REG_GRID_COLS, 7'd0, 1'b0, 16'd0,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'hFFFF,  1'b1, 23'd65535,  1'b1},
        // rock on the start cell still counts as reached, value dropped
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b1, 16'd1234,  1'b1, 23'd0,      1'b1},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'd0,     1'b1, 23'd0,      1'b1},
        // 1x2 grid: rock on the end cell, then rock start with open end
        '{ROW_CFG,  REG_GRID_COLS, 7'd2, 1'b0, 16'd0,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'd5,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b1, 16'd7,     1'b1, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b1, 16'd9,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'hFFFF,  1'b1, 23'd65535,  1'b1},
        // 2x2 grid: end cell walled off by rocks above and to the left
        '{ROW_CFG,  REG_GRID_ROWS, 7'd2, 1'b0, 16'd0,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'd1,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b1, 16'd0,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b1, 16'd0,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'd3,     1'b1, 23'd0,      1'b0},
        // 2x2 grid: max of above and left
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'd1,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'd2,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'd10,    1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'd3,     1'b0, 23'd0,      1'b0},
        // half a grid, then a column write restarts at the top-left cell
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'hFFFF,  1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'hFFFF,  1'b0, 23'd0,      1'b0},
        '{ROW_CFG,  REG_GRID_COLS, 7'd1, 1'b0, 16'd0,     1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'hFFFF,  1'b0, 23'd0,      1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 7'd0, 1'b0, 16'hFFFF,  1'b1, 23'd131070, 1'b1}
    };

    // ------------------------------------------------------------------------
    // dut signals, the bench-driven ones known from time 0
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [ADDR_W-1:0]      cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;   // [15:0] cell_value
    logic                   s_tuser   = 1'b0; // [0] is_rock
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // [22:0] best_amount, [23] zero
    logic                   m_tuser;          // [0] path_found

    grid_max_path_sum_core #(
        .MAX_ROWS (GRID_MAX),
        .MAX_COLS (GRID_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor state: register copies, row of best sums, scan position
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]   size_rows = GRID_ROWS_RESET;
    logic [CFG_W-1:0]   size_cols = GRID_COLS_RESET;
    int unsigned        above_sum [GRID_MAX];
    bit                 above_ok  [GRID_MAX];
    int unsigned        left_sum  = 0;
    bit                 left_ok   = 1'b0;
    int unsigned        scan_row  = 0;
    int unsigned        scan_col  = 0;

    path_result_t       pending_paths [$];    // results still owed by the block
    int unsigned        err_count   = 0;
    int unsigned        cells_taken = 0;

    // pacing controls; sink_idle and hold_req are shared with the receiver process
    bit                 send_idle = 1'b1;
    bit                 sink_idle = 1'b1;
    bit                 hold_req  = 1'b0;

    // register value 0 means one, anything past the instance size saturates
    function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > GRID_MAX)
            return GRID_MAX;
        return v;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // one cell of the row-by-row dynamic program; done marks the end cell
    task automatic advance_scan(input logic rock, input logic [VAL_W-1:0] value,
                                output bit done, output path_result_t res);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        int unsigned best;
        bit          ok;
        rows = dim_in_use(size_rows);
        cols = dim_in_use(size_cols);
        r    = (scan_row >= rows) ? 0 : scan_row;
        c    = (scan_col >= cols) ? 0 : scan_col;
        ok   = 1'b0;
        best = 0;
        done = 1'b0;
        res  = '0;

        if (r == 0 && c == 0)
        begin
            // start cell is reached even when it is a rock
            ok   = 1'b1;
            best = rock ? 0 : value;
        end
        else if (!rock)
        begin
            if (r > 0 && above_ok[c])
            begin
                ok   = 1'b1;
                best = above_sum[c];
            end
            if (c > 0 && left_ok)
            begin
                if (!ok || left_sum > best)
                    best = left_sum;
                ok = 1'b1;
            end
            if (ok)
            begin
                best = best + value;
                if (best > SUM_MAX)
                    best = SUM_MAX;
            end
            else
                best = 0;
        end

        above_sum[c] = best;
        above_ok[c]  = ok;
        left_sum     = best;
        left_ok      = ok;

        if (c + 1 < cols)
        begin
            scan_col = c + 1;
            scan_row = r;
        end
        else
        begin
            scan_col = 0;
            left_sum = 0;
            left_ok  = 1'b0;
            if (r + 1 < rows)
                scan_row = r + 1;
            else
            begin
                scan_row   = 0;
                done       = 1'b1;
                res.amount = ok ? SUM_W'(best) : '0;
                res.found  = ok;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    // offers one cell request, waits for the handshake, then predicts
    task automatic send_cell(input logic rock, input logic [VAL_W-1:0] value,
                             input bit typed, input path_result_t typed_res);
        int unsigned  gap;
        bit           done;
        path_result_t res;
        gap = (send_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= rock;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_scan(rock, value, done, res);
        if (done)
            pending_paths.push_back(typed ? typed_res : res);
        cells_taken++;
    endtask

    task automatic send_random_cell(input int unsigned rock_odds);
        logic rock;
        rock = (rock_odds != 0) && ($urandom_range(0, rock_odds - 1) == 0);
        send_cell(rock, rand_value(), 1'b0, '0);
    endtask

    // stop offering and wait until every owed result has left, plus the
    // output register, so a partial grid cannot still be in flight
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_paths.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes one register; any listed register restarts the scan
    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GRID_ROWS: size_rows = value;
            REG_GRID_COLS: size_cols = value;
            default: ;
        endcase
        scan_row = 0;
        scan_col = 0;
        left_sum = 0;
        left_ok  = 1'b0;
    endtask

    // one random phase: pick a shape, write it, stream a few whole grids
    // and now and then a partial one that the next write cuts short
    task automatic run_phase(input int unsigned idx);
        logic [CFG_W-1:0] rows_raw;
        logic [CFG_W-1:0] cols_raw;
        int unsigned      pick;
        int unsigned      which;
        int unsigned      cells;
        int unsigned      n_grids;
        int unsigned      rock_odds;
        int unsigned      partial;
        pick  = $urandom_range(0, 19);
        which = (idx < 6) ? 2 : $urandom_range(0, 5);
        case (idx)
            // clamp and depth extremes first, then random shapes
            0: begin rows_raw = 7'd127; cols_raw = 7'd1;   end
            1: begin rows_raw = 7'd1;   cols_raw = 7'd127; end
            2: begin rows_raw = 7'd64;  cols_raw = 7'd2;   end
            3: begin rows_raw = 7'd3;   cols_raw = 7'd64;  end
            4: begin rows_raw = 7'd65;  cols_raw = 7'd0;   end
            5: begin rows_raw = 7'd1;   cols_raw = 7'd1;   end
            default:
            begin
                if (pick < 14)
                begin
                    rows_raw = CFG_W'($urandom_range(1, 8));
                    cols_raw = CFG_W'($urandom_range(1, 8));
                end
                else if (pick < 16)
                begin
                    rows_raw = CFG_W'($urandom_range(9, 16));
                    cols_raw = CFG_W'($urandom_range(9, 16));
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       rows_raw = 7'd0;
                        1:       rows_raw = 7'd64;
                        2:       rows_raw = 7'd127;
                        default: rows_raw = CFG_W'($urandom_range(65, 127));
                    endcase
                    cols_raw = CFG_W'($urandom_range(1, 3));
                    if (pick >= 18)
                    begin
                        cols_raw = rows_raw;
                        rows_raw = CFG_W'($urandom_range(1, 3));
                    end
                end
            end
        endcase

        drain_results();
        send_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        // usually both registers, sometimes only one of them
        if (which != 1)
            write_reg(REG_GRID_ROWS, rows_raw);
        if (which != 0)
            write_reg(REG_GRID_COLS, cols_raw);

        cells   = dim_in_use(size_rows) * dim_in_use(size_cols);
        n_grids = (cells > 64) ? 1 : $urandom_range(1, 4);
        case ($urandom_range(0, 5))
            0:       rock_odds = 0;
            1:       rock_odds = 2;
            2:       rock_odds = 4;
            default: rock_odds = 8;
        endcase

        for (int g = 0; g < n_grids; g++)
        begin
            for (int k = 0; k < cells; k++)
                send_random_cell(rock_odds);
            // now and then the sender pauses until the block has handed back everything
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
        if (cells > 1 && $urandom_range(0, 3) == 0)
        begin
            partial = $urandom_range(1, cells - 1);
            for (int k = 0; k < partial; k++)
                send_random_cell(rock_odds);
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver pacing: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : sink_pace
        int unsigned stall;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_idle && $urandom_range(0, 3) == 0)
            begin
                stall = idle_len();
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every accepted result request against the oldest entry
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : path_check
        path_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_paths.size() == 0)
            begin
                $error("unexpected result: best_amount %0d path_found %0b",
                       m_tdata[SUM_W-1:0], m_tuser);
                err_count++;
            end
            else
            begin
                want = pending_paths.pop_front();
                if (m_tdata[SUM_W-1:0] !== want.amount)
                begin
                    $error("best_amount: expected %0d, got %0d",
                           want.amount, m_tdata[SUM_W-1:0]);
                    err_count++;
                end
                if (m_tuser !== want.found)
                begin
                    $error("path_found: expected %0b, got %0b", want.found, m_tuser);
                    err_count++;
                end
                if (m_tdata[OUT_DATA_W-1:SUM_W] !== '0)
                begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[OUT_DATA_W-1:SUM_W]);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned  phase;
        path_result_t typed_res;
        phase = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, config rows only once the block is idle
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(DIRECTED[i].addr, DIRECTED[i].wdata);
            end
            else
            begin
                typed_res.amount = DIRECTED[i].amount;
                typed_res.found  = DIRECTED[i].found;
                send_cell(DIRECTED[i].rock, DIRECTED[i].value, DIRECTED[i].typed, typed_res);
            end
        end

        // back-pressure: receiver holds off while three 4x4 grids are offered,
        // so one result waits and the last cell of the next grid is stalled
        drain_results();
        write_reg(REG_GRID_ROWS, 7'd4);
        write_reg(REG_GRID_COLS, 7'd4);
        send_idle = 1'b0;
        hold_req  = 1'b1;
        for (int k = 0; k < 48; k++)
            send_random_cell(8);

        // random phases until enough cells have been taken
        while (cells_taken < TOTAL_CELLS)
        begin
            run_phase(phase);
            phase++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // hard stop in case a handshake never completes
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/gmps_pkg.sv
rtl/gmps_cell.sv
rtl/gmps_chain.sv
rtl/gmps_update.sv
rtl/grid_max_path_sum_core.sv
rtl/gmps_checker.sv
tb/tb_grid_max_path_sum_core.sv
